[sv/kra_pkg.sv]
// Shared types and constants for the key and role access table.
// Beat payload structs, status, role and mode codes, key store request.
// No dependencies.
`default_nettype none

package kra_pkg;

    localparam int KEY_W      = 256;
    localparam int WORD_W     = 64;
    localparam int SLOT_IDX_W = 4;
    localparam int GEN_W      = 32;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REVOKE = 2'd2,
        MODE_INIT   = 2'd3
    } kra_mode_t;

    typedef enum logic [1:0] {
        ROLE_NONE     = 2'd0,
        ROLE_OPERATOR = 2'd1,
        ROLE_ADMIN    = 2'd2,
        ROLE_RECOVERY = 2'd3
    } kra_role_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ARGUMENT  = 3'd1,
        ST_ROLE      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_IMMUTABLE = 3'd5,
        ST_NOT_FOUND = 3'd6
    } kra_status_t;

    // Request beat
    typedef struct packed {
        logic [1:0]            mode;
        logic [WORD_W-1:0]     key_word0;
        logic [WORD_W-1:0]     key_word1;
        logic [WORD_W-1:0]     key_word2;
        logic [WORD_W-1:0]     key_word3;
        logic [1:0]            new_role;
        logic [SLOT_IDX_W-1:0] caller_idx;
        logic [SLOT_IDX_W-1:0] revoke_idx;
    } kra_in_t;

    // Response beat
    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [1:0]            role_found;
        logic [GEN_W-1:0]      generation_now;
    } kra_out_t;

    // Sequencer to key store: one read and one write port
    typedef struct packed {
        logic                  rd_en;
        logic [SLOT_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [SLOT_IDX_W-1:0] wr_addr;
    } kra_mem_req_t;

endpackage

`default_nettype wire

[sv/kra_key_store.sv]
// Key store: one 256-bit key row per slot, registered read, and the shared
// key comparator that checks the row read last against the operand key.
// Depends on kra_pkg.
`default_nettype none

module kra_key_store #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                        clk,
    input  kra_pkg::kra_mem_req_t      mem_req,
    input  wire [kra_pkg::KEY_W-1:0]   key,
    output logic                       match
);
    import kra_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    // Rows are qualified by the slot roles, so no reset is needed here
    logic [KEY_W-1:0] mem [SLOT_COUNT];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr[IDX_W-1:0]] <= key;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr[IDX_W-1:0]];
        end
    end

    // Shared comparator
    assign match = (rd_data_reg == key);

endmodule

`default_nettype wire

[sv/kra_seq.sv]
// Operation sequencer: holds the slot roles and generation counter, runs
// the slot scan over the key store and builds one response per request.
// Depends on kra_pkg; drives kra_key_store through a kra_mem_req_t.
`default_nettype none

module kra_seq #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         req_valid,
    output logic                        req_stall,
    input  kra_pkg::kra_in_t            req,
    output logic                        res_valid,
    input  wire                         res_take,
    output kra_pkg::kra_out_t           res,
    output kra_pkg::kra_mem_req_t       mem_req,
    output logic [kra_pkg::KEY_W-1:0]   key,
    input  wire                         match
);
    import kra_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int LIM_W = SLOT_IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(SLOT_COUNT);
    localparam logic [LIM_W-1:0] SLOT_LIM = LIM_W'(SLOT_COUNT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SCAN  = 5'b00100,
        S_REV   = 5'b01000,
        S_EMIT  = 5'b10000
    } kra_state_t;

    kra_state_t             state_reg, state_next;
    logic [1:0]             roles_reg [SLOT_COUNT];
    logic [1:0]             roles_next [SLOT_COUNT];
    logic [GEN_W-1:0]       gen_reg, gen_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    kra_in_t                op_reg;
    logic [2:0]             status_reg, status_next;
    logic [SLOT_IDX_W-1:0]  slot_reg, slot_next;
    logic [1:0]             role_reg, role_next;

    logic                   req_accept;
    logic                   op_key_zero;
    logic                   caller_ok;
    logic                   target_ok;
    logic [IDX_W-1:0]       role_idx;
    logic [1:0]             role_rd;
    logic                   rd_admin;
    logic                   hit;
    logic                   free_now_vld;
    logic [IDX_W-1:0]       free_now_idx;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_valid  = (state_reg == S_EMIT);

    assign key = {op_reg.key_word3, op_reg.key_word2, op_reg.key_word1, op_reg.key_word0};
    assign op_key_zero = (key == '0);
    assign caller_ok = ({1'b0, op_reg.caller_idx} < SLOT_LIM);
    assign target_ok = ({1'b0, op_reg.revoke_idx} < SLOT_LIM);

    // Single role read port, address chosen by state
    always_comb
    begin
        case (state_reg)
            S_REV:   role_idx = op_reg.revoke_idx[IDX_W-1:0];
            S_SCAN:  role_idx = chk_idx_reg;
            default: role_idx = op_reg.caller_idx[IDX_W-1:0];
        endcase
    end
    assign role_rd  = roles_reg[role_idx];
    assign rd_admin = (role_rd == ROLE_ADMIN) || (role_rd == ROLE_RECOVERY);

    // Scan compare of the row read last cycle, plus first free slot above 0
    assign hit = chk_vld_reg && (role_rd != ROLE_NONE) && match;
    assign free_now_vld = free_vld_reg ||
                          (chk_vld_reg && (role_rd == ROLE_NONE) && (chk_idx_reg != '0));
    assign free_now_idx = free_vld_reg ? free_idx_reg : chk_idx_reg;

    assign res.status         = status_reg;
    assign res.slot_index     = slot_reg;
    assign res.role_found     = role_reg;
    assign res.generation_now = gen_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        roles_next    = roles_reg;
        gen_next      = gen_reg;
        iss_next      = iss_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        role_next     = role_reg;
        mem_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next   = ST_OK;
                slot_next     = '0;
                role_next     = ROLE_NONE;
                iss_next      = '0;
                free_vld_next = 1'b0;
                state_next    = S_EMIT;
                case (op_reg.mode)
                    MODE_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    MODE_ADD:
                    begin
                        if (op_key_zero || !((op_reg.new_role == ROLE_OPERATOR) ||
                                             (op_reg.new_role == ROLE_ADMIN)))
                        begin
                            status_next = ST_ARGUMENT;
                        end
                        else if (!caller_ok || !rd_admin)
                        begin
                            status_next = ST_ROLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    MODE_REVOKE:
                    begin
                        if (!caller_ok || !target_ok)
                        begin
                            status_next = ST_ARGUMENT;
                        end
                        else if (!rd_admin)
                        begin
                            status_next = ST_ROLE;
                        end
                        else if (op_reg.revoke_idx == '0)
                        begin
                            status_next = ST_IMMUTABLE;
                        end
                        else
                        begin
                            state_next = S_REV;
                        end
                    end
                    default:
                    begin
                        // initialise
                        if (op_key_zero)
                        begin
                            status_next = ST_ARGUMENT;
                        end
                        else
                        begin
                            for (int s = 0; s < SLOT_COUNT; s++)
                            begin
                                roles_next[s] = ROLE_NONE;
                            end
                            roles_next[0]   = ROLE_RECOVERY;
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = '0;
                            gen_next        = GEN_W'(1);
                        end
                    end
                endcase
            end

            S_REV:
            begin
                state_next = S_EMIT;
                if (role_rd == ROLE_NONE)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    roles_next[op_reg.revoke_idx[IDX_W-1:0]] = ROLE_NONE;
                    gen_next = gen_reg + GEN_W'(1);
                end
            end

            S_SCAN:
            begin
                // issue the next row read
                if (iss_reg < CNT_LIM)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = SLOT_IDX_W'(iss_reg);
                    iss_next        = iss_reg + CNT_W'(1);
                    chk_vld_next    = 1'b1;
                    chk_idx_next    = iss_reg[IDX_W-1:0];
                end
                free_vld_next = free_now_vld;
                free_idx_next = free_now_idx;

                // check the row read last cycle
                if (hit)
                begin
                    state_next = S_EMIT;
                    if (op_reg.mode == MODE_FIND)
                    begin
                        slot_next = SLOT_IDX_W'(chk_idx_reg);
                        role_next = role_rd;
                    end
                    else
                    begin
                        status_next = ST_DUPLICATE;
                    end
                end
                else if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next = S_EMIT;
                    if (op_reg.mode == MODE_FIND)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (free_now_vld)
                    begin
                        roles_next[free_now_idx] = op_reg.new_role;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = SLOT_IDX_W'(free_now_idx);
                        gen_next        = gen_reg + GEN_W'(1);
                        slot_next       = SLOT_IDX_W'(free_now_idx);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
            end

            S_EMIT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gen_reg     <= '0;
            chk_vld_reg <= 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                roles_reg[s] <= ROLE_NONE;
            end
        end
        else
        begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            chk_vld_reg <= chk_vld_next;
            roles_reg   <= roles_next;
        end
    end

    // Operand and working registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg <= req;
        end
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        role_reg     <= role_next;
    end

endmodule

`default_nettype wire

[sv/key_role_access_table.sv]
// Top level of the key and role access table: sequencer, key store and
// response output register. Depends on kra_pkg, kra_seq, kra_key_store.
//
// Usage:
//   Request channel req / req_valid / req_stall carries one operation per
//   beat (find, add, revoke, initialise). Response channel rsp / rsp_valid /
//   rsp_stall returns exactly one beat per request, in order.
//   One request is worked on at a time; req_stall is high from the accept
//   until the result moves into the output register.
//   Find and add run a slot scan through the single key store read port
//   and key comparator, one slot per cycle, each row read registered
//   before its compare; a find or duplicate hit ends the scan early.
//   Revoke passes through a role check state; initialise and rejected
//   requests go from the start state straight to the response.
//   A waiting response sits in the output register while the next request
//   is accepted; a stalled receiver holds rsp stable and, once the
//   sequencer has a second result, holds req_stall high.
//   Reset empties every slot and clears the generation counter; the key
//   rows themselves are not cleared since an empty slot never matches.
`default_nettype none

module key_role_access_table #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  kra_pkg::kra_in_t    req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output kra_pkg::kra_out_t   rsp
);
    import kra_pkg::*;

    kra_mem_req_t        mem_req;
    logic [KEY_W-1:0]    key;
    logic                match;
    logic                res_valid;
    logic                res_take;
    kra_out_t            res;
    logic                rsp_valid_reg;
    kra_out_t            rsp_reg;

    kra_seq #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_req   (mem_req),
        .key       (key),
        .match     (match)
    );

    kra_key_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .key     (key),
        .match   (match)
    );

    // Output register: free when empty or being drained this cycle
    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[sv/kra_checker.sv]
// Port level checks for key_role_access_table, attached by bind.
// Depends on kra_pkg and the top level port list.
`default_nettype none

module kra_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    input  wire                 req_stall,
    input  kra_pkg::kra_out_t   rsp,
    input  wire                 rsp_valid,
    input  wire                 rsp_stall
);
    import kra_pkg::*;

    // A stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous one in progress");

    // No response can appear the cycle after an accept
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !$rose(rsp_valid))
        else $error("response appeared too early");

    // Failed operations report no slot and no role
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.slot_index == '0) &&
                                               (rsp.role_found == ROLE_NONE))
        else $error("failed operation returned slot or role");

endmodule

bind key_role_access_table kra_checker u_kra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for key_role_access_table: directed and random
// find/add/revoke/initialise traffic, checked against an in-bench table model.
// Depends on kra_pkg and the key_role_access_table RTL.
`timescale 1ns / 1ps

module tb;
    import kra_pkg::*;

    localparam int SLOT_N      = 8;
    localparam int RANDOM_OPS  = 1125;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 400;   // response count that starts the long hold
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_EVERY = 300;

    typedef struct packed {
        logic    drain;    // wait for every response before offering this beat
        kra_in_t op;
    } queued_op_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    kra_in_t    req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    kra_out_t   rsp;

    queued_op_t request_q [$];
    kra_out_t   access_rsp_q [$];
    logic [255:0] key_pool [$];

    // table model state
    kra_role_t    tbl_role [SLOT_N];
    logic [255:0] tbl_key [SLOT_N];
    logic [31:0]  tbl_gen;

    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit hold_done = 1'b0;
    int status_hits [8];

    key_role_access_table #(
        .SLOT_COUNT (SLOT_N)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Table model
    // ---------------------------------------------------------------
    function automatic int lookup_slot(logic [255:0] k);
        for (int s = 0; s < SLOT_N; s++)
        begin
            if (tbl_role[s] != ROLE_NONE && tbl_key[s] == k)
                return s;
        end
        return SLOT_N;
    endfunction

    function automatic bit caller_admin(logic [3:0] c);
        if (c >= SLOT_N)
            return 1'b0;
        return tbl_role[c] == ROLE_ADMIN || tbl_role[c] == ROLE_RECOVERY;
    endfunction

    // Applies one request to the table model and returns its response beat.
    function automatic kra_out_t predict_access(kra_in_t op);
        logic [255:0] k;
        kra_out_t     r;
        int           hit;
        bit           placed;
        k = {op.key_word3, op.key_word2, op.key_word1, op.key_word0};
        r = '0;
        r.status = ST_OK;
        case (op.mode)
            MODE_FIND:
            begin
                hit = lookup_slot(k);
                if (hit < SLOT_N)
                begin
                    r.slot_index = hit[3:0];
                    r.role_found = tbl_role[hit];
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_ADD:
            begin
                if (k == '0 || !(op.new_role == ROLE_OPERATOR || op.new_role == ROLE_ADMIN))
                    r.status = ST_ARGUMENT;
                else if (!caller_admin(op.caller_idx))
                    r.status = ST_ROLE;
                else if (lookup_slot(k) < SLOT_N)
                    r.status = ST_DUPLICATE;
                else
                begin
                    r.status = ST_FULL;
                    placed = 1'b0;
                    for (int s = 1; s < SLOT_N; s++)
                    begin
                        if (!placed && tbl_role[s] == ROLE_NONE)
                        begin
                            tbl_role[s] = kra_role_t'(op.new_role);
                            tbl_key[s] = k;
                            tbl_gen = tbl_gen + 32'd1;
                            r.slot_index = s[3:0];
                            r.status = ST_OK;
                            placed = 1'b1;
                        end
                    end
                end
            end
            MODE_REVOKE:
            begin
                if (op.caller_idx >= SLOT_N || op.revoke_idx >= SLOT_N)
                    r.status = ST_ARGUMENT;
                else if (!caller_admin(op.caller_idx))
                    r.status = ST_ROLE;
                else if (op.revoke_idx == 0)
                    r.status = ST_IMMUTABLE;
                else if (tbl_role[op.revoke_idx] == ROLE_NONE)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    tbl_role[op.revoke_idx] = ROLE_NONE;
                    tbl_key[op.revoke_idx] = '0;
                    tbl_gen = tbl_gen + 32'd1;
                end
            end
            default:
            begin
                if (k == '0)
                    r.status = ST_ARGUMENT;
                else
                begin
                    for (int s = 0; s < SLOT_N; s++)
                    begin
                        tbl_role[s] = ROLE_NONE;
                        tbl_key[s] = '0;
                    end
                    tbl_role[0] = ROLE_RECOVERY;
                    tbl_key[0] = k;
                    tbl_gen = 32'd1;
                end
            end
        endcase
        r.generation_now = tbl_gen;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [255:0] rand_key();
        logic [255:0] k;
        for (int w = 0; w < 8; w++)
            k[w*32 +: 32] = $urandom;
        // sometimes only one 64-bit word carries data
        if ($urandom_range(0, 9) == 0)
            k = k & ({192'd0, 64'hffff_ffff_ffff_ffff} << (64 * $urandom_range(0, 3)));
        return k;
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] pick_caller();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 4'd0;
        if (r < 90)
            return 4'($urandom_range(1, SLOT_N - 1));
        return 4'($urandom_range(SLOT_N, 15));
    endfunction

    task automatic push_op(kra_mode_t m, logic [255:0] k, logic [1:0] role,
                           logic [3:0] caller, logic [3:0] target, bit drain);
        queued_op_t q;
        q.drain = drain;
        q.op.mode = m;
        q.op.key_word0 = k[63:0];
        q.op.key_word1 = k[127:64];
        q.op.key_word2 = k[191:128];
        q.op.key_word3 = k[255:192];
        q.op.new_role = role;
        q.op.caller_idx = caller;
        q.op.revoke_idx = target;
        request_q.push_back(q);
    endtask

    // Random part: mostly well-formed table traffic, some malformed beats.
    task automatic fill_random_ops();
        logic [255:0] k;
        logic [1:0]   role;
        int           r;
        int           pick;
        bit           drain;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            drain = (n % DRAIN_EVERY) == DRAIN_EVERY - 1;
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (r < 3)
            begin
                // initialise; a quarter of them with a zero key
                k = (pick < 25) ? '0 : rand_key();
                if (k != '0)
                    key_pool.push_back(k);
                push_op(MODE_INIT, k, 2'($urandom), 4'($urandom), 4'($urandom), drain);
            end
            else if (r < 35)
            begin
                // find: known key, near miss, random or zero
                if (pick < 60 && key_pool.size() != 0)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else if (pick < 75 && key_pool.size() != 0)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)]
                        ^ (256'd1 << $urandom_range(0, 255));
                else if (pick < 90)
                    k = rand_key();
                else
                    k = '0;
                push_op(MODE_FIND, k, 2'($urandom), 4'($urandom), 4'($urandom), drain);
            end
            else if (r < 70)
            begin
                // add: mostly fresh keys, some duplicates and bad arguments
                if (pick < 70 || key_pool.size() == 0)
                begin
                    k = rand_key();
                    key_pool.push_back(k);
                end
                else if (pick < 92)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else
                    k = '0;
                role = ($urandom_range(0, 99) < 88) ? 2'($urandom_range(1, 2))
                                                    : (($urandom_range(0, 1) == 1) ? 2'd3 : 2'd0);
                push_op(MODE_ADD, k, role, pick_caller(), 4'($urandom), drain);
            end
            else
            begin
                // revoke: targets mostly in range
                push_op(MODE_REVOKE, rand_key(), 2'($urandom), pick_caller(),
                        (pick < 85) ? 4'($urandom_range(0, SLOT_N - 1))
                                    : 4'($urandom_range(SLOT_N, 15)), drain);
            end
            if (key_pool.size() > 16)
                key_pool.delete($urandom_range(0, key_pool.size() - 1));
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver: offers queued beats, predicts on each accepted beat
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                access_rsp_q.push_back(predict_access(req));
                beats_sent++;
                // a stretch with no sender idling
                send_gap = (beats_sent >= 700 && beats_sent < 800) ? 0 : pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (request_q.size() != 0 &&
                     (!request_q[0].drain || access_rsp_q.size() == 0))
            begin
                req <= request_q[0].op;
                req_valid <= 1'b1;
                void'(request_q.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Response monitor: checks each beat, drives the receiver stall
    // ---------------------------------------------------------------
    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kra_out_t want;
        int       n;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (access_rsp_q.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = access_rsp_q.pop_front();
                    report_field("status", 32'(want.status), 32'(rsp.status));
                    report_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
                    report_field("role_found", 32'(want.role_found), 32'(rsp.role_found));
                    report_field("generation_now", want.generation_now, rsp.generation_now);
                    status_hits[want.status]++;
                end
                beats_checked++;
            end
            // one long hold so the block backs up into req_stall
            if (!hold_done && beats_checked >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (beats_checked >= 700 && beats_checked < 800)
                rsp_stall <= 1'b0;
            else
            begin
                n = pick_gap();
                stall_left = (n > 0) ? n - 1 : 0;
                rsp_stall <= (n > 0);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** key_role_access_table: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        logic [255:0] ones;
        logic [255:0] fill_key [SLOT_N];
        for (int s = 0; s < SLOT_N; s++)
        begin
            tbl_role[s] = ROLE_NONE;
            tbl_key[s] = '0;
            fill_key[s] = rand_key() | 256'd1;
        end
        tbl_gen = '0;
        ones = '1;

        // directed: empty table, argument checks, fill, revoke checks
        push_op(MODE_FIND, '0, 2'd0, 4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_OPERATOR, 4'd0, 4'd0, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd0, 4'd1, 1'b0);
        push_op(MODE_INIT, '0, 2'd0, 4'd0, 4'd0, 1'b0);
        push_op(MODE_INIT, ones, 2'd3, 4'd15, 4'd15, 1'b0);
        push_op(MODE_FIND, ones, 2'd0, 4'd0, 4'd0, 1'b0);
        push_op(MODE_FIND, '0, 2'd0, 4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, '0, ROLE_OPERATOR, 4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_NONE, 4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_RECOVERY, 4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_OPERATOR, 4'd15, 4'd0, 1'b0);
        push_op(MODE_ADD, ones, ROLE_ADMIN, 4'd0, 4'd0, 1'b0);
        // odd slots admin, even slots operator
        for (int s = 1; s < SLOT_N; s++)
            push_op(MODE_ADD, fill_key[s], (s % 2 == 1) ? ROLE_ADMIN : ROLE_OPERATOR,
                    4'd0, 4'd0, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_ADMIN, 4'd0, 4'd0, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd8, 4'd1, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd0, 4'd9, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd2, 4'd1, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd0, 4'd0, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd1, 4'd3, 1'b0);
        push_op(MODE_REVOKE, '0, 2'd0, 4'd0, 4'd3, 1'b0);
        push_op(MODE_ADD, fill_key[0], ROLE_OPERATOR, 4'd1, 4'd0, 1'b0);
        push_op(MODE_FIND, fill_key[5], 2'd0, 4'd0, 4'd0, 1'b0);
        for (int s = 0; s < SLOT_N; s++)
            key_pool.push_back(fill_key[s]);
        key_pool.push_back(ones);
        fill_random_ops();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid)
            @(posedge clk);
        while (access_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SLOT_N + 8) @(posedge clk);

        $display("Ran %0d request beats and checked %0d response beats in %0d cycles.",
                 beats_sent, beats_checked, cycle_count);
        $display("Status mix: ok %0d, arg %0d, role %0d, dup %0d, full %0d, immut %0d, miss %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6]);
        if (errors == 0)
            $display("** key_role_access_table: PASSED **");
        else
            $display("** key_role_access_table: FAILED **");
        $finish;
    end

endmodule

[key_role_access_table.f]
sv/kra_pkg.sv
sv/kra_key_store.sv
sv/kra_seq.sv
sv/key_role_access_table.sv
sv/kra_checker.sv
test/tb.sv
